FILE: rtl/gbl_pkg.sv
package gbl_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int MIN_SIZE     = 5;

   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int LINE_W       = 32;
   localparam int VSUM_W       = 12;
   localparam int HSUM_W       = 16;
   localparam int TAPS         = 5;

   localparam int FQ_DEPTH     = 4;
   localparam int FQ_PTR_W     = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W     = $clog2(FQ_DEPTH + 1);
   localparam int OQ_DEPTH     = 4;
   localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W     = $clog2(OQ_DEPTH + 3);

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [COL_W-1:0] RESET_WIDTH_LAST  = COL_W'(640 - 1);
   localparam logic [ROW_W-1:0] RESET_HEIGHT_LAST = ROW_W'(480 - 1);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic             first_row;
      logic             emit;
      logic             last;
   } gbl_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } gbl_result_type;

endpackage

FILE: rtl/gbl_ram.sv
module gbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gbl_front.sv
module gbl_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gbl_pkg::PIX_W-1:0]        req_in_pixel,
   input  logic                             csr_we,
   input  logic [gbl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gbl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output gbl_pkg::gbl_item_type            item,
   output logic                             item_valid,
   input  logic                             item_pop
);
   import gbl_pkg::*;

   logic [COL_W-1:0]        width_last_ff, width_last_in;
   logic [ROW_W-1:0]        height_last_ff, height_last_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   gbl_item_type            fq_mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]     fq_wr_ptr_ff, fq_wr_ptr_in;
   logic [FQ_PTR_W-1:0]     fq_rd_ptr_ff, fq_rd_ptr_in;
   logic [FQ_CNT_W-1:0]     fq_count_ff, fq_count_in;
   logic [CFG_WIDTH_W-1:0]  width_value;
   logic [CFG_HEIGHT_W-1:0] height_value;
   logic                    accept;
   logic                    restart;
   gbl_item_type            new_item;

   assign width_value  = csr_wdata[CFG_WIDTH_W-1:0];
   assign height_value = csr_wdata[CFG_HEIGHT_W-1:0];
   assign req_ready    = fq_count_ff != FQ_CNT_W'(FQ_DEPTH);
   assign accept       = req_valid && req_ready;
   assign restart      = csr_we && (csr_index == REG_IMAGE_WIDTH ||
                                    csr_index == REG_IMAGE_HEIGHT);

   // Out-of-range sizes are clamped when written, and only the last index is kept.
   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_we && csr_index == REG_IMAGE_WIDTH) begin
         if (int'(width_value) < MIN_SIZE) begin
            width_last_in = COL_W'(MIN_SIZE - 1);
         end else if (int'(width_value) > MAX_WIDTH) begin
            width_last_in = COL_W'(MAX_WIDTH - 1);
         end else begin
            width_last_in = COL_W'(width_value - CFG_WIDTH_W'(1));
         end
      end
      if (csr_we && csr_index == REG_IMAGE_HEIGHT) begin
         if (int'(height_value) < MIN_SIZE) begin
            height_last_in = ROW_W'(MIN_SIZE - 1);
         end else if (int'(height_value) > HEIGHT_LIMIT) begin
            height_last_in = ROW_W'(HEIGHT_LIMIT - 1);
         end else begin
            height_last_in = ROW_W'(height_value - CFG_HEIGHT_W'(1));
         end
      end
   end

   always_comb begin
      new_item.pixel     = req_in_pixel;
      new_item.col       = col_ff;
      new_item.first_row = row_ff == '0;
      new_item.emit      = (int'(row_ff) >= TAPS - 1) && (int'(col_ff) >= TAPS - 1);
      new_item.last      = (row_ff == height_last_ff) && (col_ff == width_last_ff);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == width_last_ff) begin
            col_in = '0;
            row_in = (row_ff == height_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      fq_wr_ptr_in = accept   ? fq_wr_ptr_ff + FQ_PTR_W'(1) : fq_wr_ptr_ff;
      fq_rd_ptr_in = item_pop ? fq_rd_ptr_ff + FQ_PTR_W'(1) : fq_rd_ptr_ff;
      fq_count_in  = fq_count_ff;
      case ({accept, item_pop})
         2'b10:   fq_count_in = fq_count_ff + FQ_CNT_W'(1);
         2'b01:   fq_count_in = fq_count_ff - FQ_CNT_W'(1);
         default: fq_count_in = fq_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= RESET_WIDTH_LAST;
         height_last_ff <= RESET_HEIGHT_LAST;
         col_ff         <= '0;
         row_ff         <= '0;
         fq_wr_ptr_ff   <= '0;
         fq_rd_ptr_ff   <= '0;
         fq_count_ff    <= '0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         fq_wr_ptr_ff   <= fq_wr_ptr_in;
         fq_rd_ptr_ff   <= fq_rd_ptr_in;
         fq_count_ff    <= fq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fq_mem_ff[fq_wr_ptr_ff] <= new_item;
      end
   end

   assign item       = fq_mem_ff[fq_rd_ptr_ff];
   assign item_valid = fq_count_ff != '0;

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= width_last_ff)
      else $error("column counter beyond the row width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_last_ff)
      else $error("row counter beyond the frame height");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart |=> col_ff == '0 && row_ff == '0)
      else $error("register write did not restart the frame");

endmodule

FILE: rtl/gbl_back.sv
module gbl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gbl_pkg::gbl_item_type      item,
   input  logic                       item_valid,
   output logic                       item_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [gbl_pkg::PIX_W-1:0]  rsp_out_pixel,
   output logic                       rsp_frame_last
);
   import gbl_pkg::*;

   logic                s1_valid_ff;
   gbl_item_type        s1_item_ff;
   logic                s2_valid_ff;
   logic                s2_emit_ff;
   logic                s2_last_ff;
   logic [VSUM_W-1:0]   col_sum_ff [TAPS];
   logic [LINE_W-1:0]   line_rd_data;
   logic [LINE_W-1:0]   above;
   logic [LINE_W-1:0]   line_wr_data;
   logic [VSUM_W-1:0]   vsum;
   logic [HSUM_W-1:0]   hsum;
   gbl_result_type      oq_mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ptr_ff, oq_wr_ptr_in;
   logic [OQ_PTR_W-1:0] oq_rd_ptr_ff, oq_rd_ptr_in;
   logic [OQ_CNT_W-1:0] oq_count_ff, oq_count_in;
   logic [OQ_CNT_W-1:0] committed;
   logic                oq_push;
   logic                oq_pop;
   gbl_result_type      result;
   gbl_result_type      head;

   // An item is issued only when the output queue has room for everything in flight.
   assign committed = oq_count_ff + OQ_CNT_W'(s1_valid_ff) + OQ_CNT_W'(s2_valid_ff);
   assign item_pop  = item_valid && (committed < OQ_CNT_W'(OQ_DEPTH));

   gbl_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_item_ff.col),
      .wr_data (line_wr_data),
      .rd_en   (item_pop),
      .rd_addr (item.col),
      .rd_data (line_rd_data)
   );

   // The line store holds the four rows above each column, oldest in the top byte.
   always_comb begin
      above        = s1_item_ff.first_row ? '0 : line_rd_data;
      line_wr_data = {above[LINE_W-PIX_W-1:0], s1_item_ff.pixel};
      vsum = VSUM_W'(above[31:24])
           + (VSUM_W'(above[23:16]) << 2)
           + (VSUM_W'(above[15:8]) << 2) + (VSUM_W'(above[15:8]) << 1)
           + (VSUM_W'(above[7:0]) << 2)
           + VSUM_W'(s1_item_ff.pixel);
   end

   always_comb begin
      hsum = HSUM_W'(col_sum_ff[0])
           + (HSUM_W'(col_sum_ff[1]) << 2)
           + (HSUM_W'(col_sum_ff[2]) << 2) + (HSUM_W'(col_sum_ff[2]) << 1)
           + (HSUM_W'(col_sum_ff[3]) << 2)
           + HSUM_W'(col_sum_ff[4]);
      result.pixel = hsum[HSUM_W-1:HSUM_W-PIX_W];
      result.last  = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= item_pop;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         s1_item_ff <= item;
      end
      if (s1_valid_ff) begin
         s2_emit_ff <= s1_item_ff.emit;
         s2_last_ff <= s1_item_ff.last;
         for (int i = 0; i < TAPS - 1; i++) begin
            col_sum_ff[i] <= col_sum_ff[i + 1];
         end
         col_sum_ff[TAPS-1] <= vsum;
      end
   end

   assign oq_push = s2_valid_ff && s2_emit_ff;
   assign oq_pop  = rsp_valid && rsp_ready;

   always_comb begin
      oq_wr_ptr_in = oq_push ? oq_wr_ptr_ff + OQ_PTR_W'(1) : oq_wr_ptr_ff;
      oq_rd_ptr_in = oq_pop  ? oq_rd_ptr_ff + OQ_PTR_W'(1) : oq_rd_ptr_ff;
      oq_count_in  = oq_count_ff;
      case ({oq_push, oq_pop})
         2'b10:   oq_count_in = oq_count_ff + OQ_CNT_W'(1);
         2'b01:   oq_count_in = oq_count_ff - OQ_CNT_W'(1);
         default: oq_count_in = oq_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         oq_wr_ptr_ff <= oq_wr_ptr_in;
         oq_rd_ptr_ff <= oq_rd_ptr_in;
         oq_count_ff  <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_mem_ff[oq_wr_ptr_ff] <= result;
      end
   end

   assign head           = oq_mem_ff[oq_rd_ptr_ff];
   assign rsp_valid      = oq_count_ff != '0;
   assign rsp_out_pixel  = head.pixel;
   assign rsp_frame_last = head.last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      oq_push |-> oq_count_ff != OQ_CNT_W'(OQ_DEPTH))
      else $error("output queue written while full");

   a_commit_bound: assert property (@(posedge clock) disable iff (reset)
      committed <= OQ_CNT_W'(OQ_DEPTH))
      else $error("more transactions in flight than output queue entries");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> s1_valid_ff)
      else $error("issued transaction did not reach the first stage");

endmodule

FILE: rtl/gaussian_blur_5x5_stream.sv
// 5x5 binomial blur on a raster-order 8-bit grayscale stream.
// Input channel req_*: one pixel per transaction, rows left to right, top to
// bottom. Result channel rsp_*: the blurred pixels of the cropped frame,
// (width-4) by (height-4), in raster order; rsp_frame_last marks the last one.
// Configuration port csr_*: index 0 sets the image width, index 1 the height.
// A write takes effect at once and restarts the frame at row 0, column 0.
// Write only while no transaction is in progress.
// Throughput is one pixel per cycle while the result channel keeps up: the
// line store is read and written once per pixel on separate ports, and every
// other stage is a register stage.
// An accepted pixel passes the input queue, the s1 and s2 registers and the
// output queue before its result, if any, appears on the result channel.
// A four-entry input queue decouples acceptance from the filter pipeline, and a
// four-entry output queue absorbs receiver stalls; the pipeline issues a pixel
// only when the output queue has room for it, so no result is dropped.
// After reset the size is 640 by 480 and the frame starts at row 0. The line
// store needs no clearing: the first row of a frame ignores its contents.
module gaussian_blur_5x5_stream (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gbl_pkg::PIX_W-1:0]        req_in_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gbl_pkg::PIX_W-1:0]        rsp_out_pixel,
   output logic                             rsp_frame_last,
   input  logic                             csr_we,
   input  logic [gbl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gbl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gbl_pkg::*;

   gbl_item_type item;
   logic         item_valid;
   logic         item_pop;

   gbl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_pixel (req_in_pixel),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item         (item),
      .item_valid   (item_valid),
      .item_pop     (item_pop)
   );

   gbl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item           (item),
      .item_valid     (item_valid),
      .item_pop       (item_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
